// ===== hw/rtl/tsip_pkg.sv =====
// package for the text to signed integer parser
// holds transaction types, character codes and the digit decode function
// no dependencies
`timescale 1ns / 1ps

package tsip_pkg;

   typedef struct packed {
      logic       start_req;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic               overflowed;
      logic               digits_seen;
      logic [15:0]        end_offset;
   } rsp_type;

   localparam logic [5:0] RADIX_MAX  = 6'd36;
   localparam logic [5:0] BASE_AUTO  = 6'd0;
   localparam logic [5:0] BASE_BIN   = 6'd2;
   localparam logic [5:0] BASE_OCT   = 6'd8;
   localparam logic [5:0] BASE_DEC   = 6'd10;
   localparam logic [5:0] BASE_HEX   = 6'd16;
   localparam logic [5:0] NOT_DIGIT  = 6'd63;

   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_PLUS    = 8'd43;
   localparam logic [7:0] CH_MINUS   = 8'd45;
   localparam logic [7:0] CH_0       = 8'd48;
   localparam logic [7:0] CH_9       = 8'd57;
   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam logic [7:0] CH_UPPER_B = 8'd66;
   localparam logic [7:0] CH_UPPER_X = 8'd88;
   localparam logic [7:0] CH_UPPER_Z = 8'd90;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_B = 8'd98;
   localparam logic [7:0] CH_LOWER_X = 8'd120;
   localparam logic [7:0] CH_LOWER_Z = 8'd122;

   localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

   function automatic logic [5:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
         d = c - CH_0;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         d = c - CH_UPPER_A + 8'd10;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         d = c - CH_LOWER_A + 8'd10;
      end else begin
         d = {2'b00, NOT_DIGIT};
      end
      return d[5:0];
   endfunction

endpackage

// ===== hw/rtl/text_to_signed_integer_parser.sv =====
// streaming text to signed 64-bit integer parser, one character per transaction
// depends on tsip_pkg
//
// usage: characters enter on the req_ channel, one per transaction; start_req
// marks the first character of a string and drops any parse in progress.
// leading white space and one sign are skipped, 0x / 0b prefixes and base 0
// auto detection follow the csr_ radix register (the user must write it only
// while idle; the block does not enforce it). the character that ends the
// number yields one rsp_ transaction with the value (saturated on overflow),
// the overflow flag, a digits flag and the end offset; later characters of
// the same string yield nothing. the result is registered and appears on rsp_
// in the cycle after the ending character is accepted. throughput: one
// character per cycle, set by the single 64x6 multiply-add and limit compare
// per character. when the receiver stalls with a result held, req_ready drops
// until it is taken. reset clears the parse state as if a new string had
// started, sets radix to 0 and empties the result register.
`timescale 1ns / 1ps

module text_to_signed_integer_parser #(
   parameter logic [31:0] MAX_LEN = 32'd65535
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsip_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tsip_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [5:0]       csr_write_data
);

   localparam logic [15:0] POS_CAP = (MAX_LEN < 32'd65535) ? MAX_LEN[15:0] : 16'hFFFF;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_SIGNED,
      PH_ZERO,
      PH_PREFIXED,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type         phase_ff, phase_in, cur_phase;
   logic              negative_ff, negative_in, cur_neg;
   logic [5:0]        base_ff, base_in;
   logic [63:0]       acc_ff, acc_in, cur_acc;
   logic              ovf_ff, ovf_in, cur_ovf;
   logic              any_ff, any_in, cur_any;
   logic [15:0]       pos_ff, pos_in, cur_pos;
   logic [5:0]        radix_ff;
   logic              rsp_valid_ff;
   tsip_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              emit;

   logic              accept;
   logic [7:0]        c;
   logic [5:0]        digit;
   logic [5:0]        step_base;
   logic [69:0]       prod;
   logic [69:0]       limit;
   logic              radix_auto_hex, radix_auto_bin, is_space;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign c     = req_data.ch;
   assign digit = tsip_pkg::digit_of(c);

   // start of a string restarts the parse before this character is used
   assign cur_phase = req_data.start_req ? PH_SKIP : phase_ff;
   assign cur_neg   = req_data.start_req ? 1'b0 : negative_ff;
   assign cur_acc   = req_data.start_req ? 64'd0 : acc_ff;
   assign cur_ovf   = req_data.start_req ? 1'b0 : ovf_ff;
   assign cur_any   = req_data.start_req ? 1'b0 : any_ff;
   assign cur_pos   = req_data.start_req ? 16'd0 : pos_ff;

   assign radix_auto_hex = (radix_ff == tsip_pkg::BASE_AUTO) || (radix_ff == tsip_pkg::BASE_HEX);
   assign radix_auto_bin = (radix_ff == tsip_pkg::BASE_AUTO) || (radix_ff == tsip_pkg::BASE_BIN);
   assign is_space = (c == tsip_pkg::CH_SPACE) || (c >= tsip_pkg::CH_TAB && c <= tsip_pkg::CH_CR);

   always_comb begin
      case (cur_phase)
         PH_SKIP, PH_SIGNED: begin
            step_base = (radix_ff == tsip_pkg::BASE_AUTO) ? tsip_pkg::BASE_DEC : radix_ff;
         end
         PH_ZERO: begin
            step_base = (radix_ff == tsip_pkg::BASE_AUTO) ? tsip_pkg::BASE_OCT : radix_ff;
         end
         default: begin
            step_base = base_ff;
         end
      endcase
   end

   assign prod  = {6'd0, cur_acc} * {64'd0, step_base} + {64'd0, digit};
   assign limit = cur_neg ? {6'd0, tsip_pkg::NEG_LIMIT} : {6'd0, tsip_pkg::POS_LIMIT};

   always_comb begin
      logic do_step;
      logic step_any;
      logic zeros;
      do_step     = 1'b0;
      step_any    = cur_any;
      zeros       = 1'b0;
      emit        = 1'b0;
      phase_in    = cur_phase;
      negative_in = cur_neg;
      base_in     = req_data.start_req ? 6'd0 : base_ff;
      acc_in      = cur_acc;
      ovf_in      = cur_ovf;
      any_in      = cur_any;
      pos_in      = (cur_pos < POS_CAP) ? cur_pos + 16'd1 : cur_pos;
      rsp_data_in = rsp_data_ff;

      if (cur_phase == PH_DONE) begin
         pos_in = cur_pos;
      end else if (radix_ff > tsip_pkg::RADIX_MAX &&
                   (cur_phase == PH_SKIP || cur_phase == PH_SIGNED || cur_phase == PH_ZERO)) begin
         emit     = 1'b1;
         zeros    = 1'b1;
         phase_in = PH_DONE;
      end else begin
         case (cur_phase)
            PH_SKIP, PH_SIGNED: begin
               if (cur_phase == PH_SKIP && is_space) begin
                  phase_in = PH_SKIP;
               end else if (cur_phase == PH_SKIP && c == tsip_pkg::CH_MINUS) begin
                  negative_in = 1'b1;
                  phase_in    = PH_SIGNED;
               end else if (cur_phase == PH_SKIP && c == tsip_pkg::CH_PLUS) begin
                  phase_in = PH_SIGNED;
               end else if (c == tsip_pkg::CH_0 && (radix_auto_hex || radix_auto_bin)) begin
                  base_in  = radix_ff;
                  phase_in = PH_ZERO;
               end else begin
                  do_step = 1'b1;
               end
            end
            PH_ZERO: begin
               if (radix_auto_hex &&
                   (c == tsip_pkg::CH_LOWER_X || c == tsip_pkg::CH_UPPER_X)) begin
                  base_in  = tsip_pkg::BASE_HEX;
                  phase_in = PH_PREFIXED;
               end else if (radix_auto_bin &&
                            (c == tsip_pkg::CH_LOWER_B || c == tsip_pkg::CH_UPPER_B)) begin
                  base_in  = tsip_pkg::BASE_BIN;
                  phase_in = PH_PREFIXED;
               end else begin
                  // the leading zero counts as a digit of value zero
                  step_any = 1'b1;
                  do_step  = 1'b1;
               end
            end
            default: begin
               do_step = 1'b1;
            end
         endcase

         if (do_step) begin
            base_in = step_base;
            any_in  = step_any;
            if (step_base == 6'd0 || digit >= step_base) begin
               emit     = 1'b1;
               phase_in = PH_DONE;
            end else begin
               if (cur_ovf || prod > limit) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = prod[63:0];
               end
               any_in   = 1'b1;
               phase_in = PH_DIGITS;
            end
         end
      end

      if (emit) begin
         if (zeros) begin
            rsp_data_in.value       = 64'sd0;
            rsp_data_in.overflowed  = 1'b0;
            rsp_data_in.digits_seen = 1'b0;
            rsp_data_in.end_offset  = 16'd0;
         end else begin
            if (cur_ovf) begin
               rsp_data_in.value = cur_neg ? tsip_pkg::NEG_LIMIT : tsip_pkg::POS_LIMIT;
            end else begin
               rsp_data_in.value = cur_neg ? 64'd0 - cur_acc : cur_acc;
            end
            rsp_data_in.overflowed  = cur_ovf;
            rsp_data_in.digits_seen = step_any;
            rsp_data_in.end_offset  = step_any ? cur_pos : 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SKIP;
         negative_ff  <= 1'b0;
         base_ff      <= 6'd0;
         acc_ff       <= 64'd0;
         ovf_ff       <= 1'b0;
         any_ff       <= 1'b0;
         pos_ff       <= 16'd0;
         radix_ff     <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            radix_ff <= csr_write_data;
         end
         if (accept) begin
            phase_ff    <= phase_in;
            negative_ff <= negative_in;
            base_ff     <= base_in;
            acc_ff      <= acc_in;
            ovf_ff      <= ovf_in;
            any_ff      <= any_in;
            pos_ff      <= pos_in;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
